### src/lbpr_pkg.sv
// shared types, constants and helpers of the lcd background pixel renderer
package lbpr_pkg;

  // video memory geometry: two byte banks split on address bit 0
  localparam int VRAM_BYTES = 8192;
  localparam int VRAM_AW    = $clog2(VRAM_BYTES);
  localparam int BANK_DEPTH = VRAM_BYTES / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // frame timing (154 lines of 456 dots, 70224 dots a frame)
  localparam int LINE_DOTS   = 456;
  localparam int FRAME_LINES = 154;
  localparam int VBLANK_LINE = 144;
  localparam int SCAN_END    = 80;
  localparam int DRAW_END    = 252;
  localparam int PIXEL_START = 92;

  // register reset values
  localparam logic [7:0] PALETTE_RESET = 8'd252;

  // output queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SCROLL_X      = 3'd0,
    CFG_SCROLL_Y      = 3'd1,
    CFG_BG_PALETTE    = 3'd2,
    CFG_BG_MAP_SELECT = 3'd3,
    CFG_TILE_UNSIGNED = 3'd4,
    CFG_LCD_ENABLE    = 3'd5
  } cfg_reg_t;

  // display modes
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OSCAN  = 2'd2,
    MODE_DRAW   = 2'd3
  } lcd_mode_t;

  // input item actions
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [VRAM_AW-1:0]   vram_addr;
    logic [7:0]           vram_data;
  } in_item_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [7:0]  pixel_x;
    logic [7:0]  line;
    logic [1:0]  shade;
    logic [31:0] argb_color;
    logic [1:0]  mode;
    logic        vblank_irq;
  } out_item_t;

  typedef struct packed {
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic [7:0] bg_palette;
    logic       bg_map_select;
    logic       tile_data_unsigned;
    logic       lcd_enable;
  } cfg_t;

  // evaluation of one item at the current frame position
  typedef struct packed {
    logic               pixel_valid;
    logic [7:0]         pixel_x;
    logic [7:0]         line;
    lcd_mode_t          mode;
    logic               vblank_irq;
    logic [2:0]         fine_y;
    logic [2:0]         fine_x;
    logic               map_bank;
    logic [BANK_AW-1:0] map_index;
  } pos_eval_t;

  // grey level of a shade
  function automatic logic [31:0] shade_argb(input logic [1:0] shade);
    logic [31:0] c;
    case (shade)
      2'd0:    c = 32'hFFFF_FFFF;
      2'd1:    c = 32'hFFAA_AAAA;
      2'd2:    c = 32'hFF55_5555;
      default: c = 32'hFF00_0000;
    endcase
    return c;
  endfunction

  // palette entry for a 2-bit color index
  function automatic logic [1:0] pal_lookup(input logic [7:0] pal, input logic [1:0] ci);
    logic [1:0] s;
    case (ci)
      2'd0:    s = pal[1:0];
      2'd1:    s = pal[3:2];
      2'd2:    s = pal[5:4];
      default: s = pal[7:6];
    endcase
    return s;
  endfunction

endpackage

### src/lbpr_ram.sv
// generic synchronous ram: one write port, two registered read ports, read-first
module lbpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### src/lbpr_pos.sv
// frame position, display mode tracking and map address of the current dot
module lbpr_pos
  import lbpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic      is_write,
  input  cfg_t      cfg,
  output pos_eval_t ev
);

  logic [8:0] dot_r, dot_nxt;
  logic [7:0] line_r, line_nxt;
  lcd_mode_t  last_mode_r, last_mode_nxt;
  lcd_mode_t  mode;
  logic       pix;
  logic [7:0] px;
  logic [7:0] y;
  logic [7:0] x;

  // position and mode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r       <= '0;
      line_r      <= '0;
      last_mode_r <= MODE_OSCAN;
    end else begin
      dot_r       <= dot_nxt;
      line_r      <= line_nxt;
      last_mode_r <= last_mode_nxt;
    end
  end

  // evaluate the current dot and advance on a tick
  always_comb begin
    pix = 1'b0;
    ev  = '0;
    if (is_write) begin
      mode = last_mode_r;
    end else if (!cfg.lcd_enable) begin
      mode = MODE_HBLANK;
    end else if (line_r >= 8'(VBLANK_LINE)) begin
      mode = MODE_VBLANK;
    end else if (dot_r < 9'(SCAN_END)) begin
      mode = MODE_OSCAN;
    end else if (dot_r < 9'(DRAW_END)) begin
      mode = MODE_DRAW;
      pix  = (dot_r >= 9'(PIXEL_START));
    end else begin
      mode = MODE_HBLANK;
    end

    px = pix ? 8'(dot_r - 9'(PIXEL_START)) : 8'd0;
    y  = line_r + cfg.scroll_y;
    x  = px + cfg.scroll_x;

    ev.pixel_valid = pix;
    ev.pixel_x     = px;
    ev.line        = line_r;
    ev.mode        = mode;
    ev.vblank_irq  = !is_write && cfg.lcd_enable && (mode == MODE_VBLANK)
                     && (last_mode_r != MODE_VBLANK);
    ev.fine_y      = y[2:0];
    ev.fine_x      = x[2:0];
    // map byte at 0x1800 + map*0x400 + row*32 + col, split over the banks
    ev.map_bank    = x[3];
    ev.map_index   = {2'b11, cfg.bg_map_select, y[7:3], x[7:4]};

    dot_nxt       = dot_r;
    line_nxt      = line_r;
    last_mode_nxt = last_mode_r;
    if (step && !is_write) begin
      if (cfg.lcd_enable) begin
        last_mode_nxt = mode;
      end
      if (dot_r == 9'(LINE_DOTS - 1)) begin
        dot_nxt  = '0;
        line_nxt = (line_r == 8'(FRAME_LINES - 1)) ? 8'd0 : line_r + 8'd1;
      end else begin
        dot_nxt = dot_r + 9'd1;
      end
    end
  end

endmodule

### src/lbpr_outq.sv
// result queue between the fetch pipeline and the output channel
module lbpr_outq
  import lbpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  out_item_t            q_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OUTQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OUTQ_CW-1:0]   cnt_r, cnt_nxt;
  logic                 pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + OUTQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + OUTQ_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + OUTQ_CW'(push) - OUTQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### src/lcd_background_pixel_renderer_core.sv
// top level of the lcd background pixel renderer
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_stall     in_data  (in_item_t)
//  out_     output     out_valid / out_stall   out_data (out_item_t)
//  cfg_     input      cfg_we                  cfg_index, cfg_wdata
//
// one item per cycle while in_stall is low; a result passes the map byte read,
// the tile row read from both banks and then the output queue before it leaves
// after reset a clearing pass zeroes all 4096 addresses of both banks, in_stall high
// in_stall depends only on the clearing pass and the count of results not yet taken, never combinationally on out_stall
// the four-entry output queue keeps the pipeline running while the output stalls
module lcd_background_pixel_renderer_core
  import lbpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  cfg_t               cfg_r;
  logic               clr_busy_r;
  logic [BANK_AW-1:0] clr_idx_r;
  logic [OUTQ_CW-1:0] pend_r, pend_nxt;
  logic               in_xfer;
  logic               out_xfer;
  logic               is_write;
  pos_eval_t          ev;

  logic               s1_vld_r, s2_vld_r;
  pos_eval_t          s1_r, s2_r;

  logic               ev_we, od_we;
  logic [BANK_AW-1:0] waddr;
  logic [7:0]         wdata;
  logic [7:0]         ev_a, od_a, ev_b, od_b;
  logic [7:0]         map_byte;
  logic [BANK_AW-1:0] tile_idx;
  logic [2:0]         bit_sel;
  logic [1:0]         ci;
  logic [1:0]         shade;
  out_item_t          res;

  assign in_stall = clr_busy_r || (pend_r == OUTQ_CW'(OUTQ_DEPTH));
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign is_write = (in_data.action == ACT_WRITE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scroll_x           <= '0;
      cfg_r.scroll_y           <= '0;
      cfg_r.bg_palette         <= PALETTE_RESET;
      cfg_r.bg_map_select      <= 1'b0;
      cfg_r.tile_data_unsigned <= 1'b1;
      cfg_r.lcd_enable         <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCROLL_X:      cfg_r.scroll_x           <= cfg_wdata;
        CFG_SCROLL_Y:      cfg_r.scroll_y           <= cfg_wdata;
        CFG_BG_PALETTE:    cfg_r.bg_palette         <= cfg_wdata;
        CFG_BG_MAP_SELECT: cfg_r.bg_map_select      <= cfg_wdata[0];
        CFG_TILE_UNSIGNED: cfg_r.tile_data_unsigned <= cfg_wdata[0];
        CFG_LCD_ENABLE:    cfg_r.lcd_enable         <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clearing pass over both banks after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + BANK_AW'(1);
      if (clr_idx_r == '1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // results accepted but not yet taken
  always_comb begin
    pend_nxt = pend_r + OUTQ_CW'(in_xfer) - OUTQ_CW'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // frame position and map address
  lbpr_pos u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_xfer),
    .is_write (is_write),
    .cfg      (cfg_r),
    .ev       (ev)
  );

  // write port: clearing pass or a byte write transfer
  always_comb begin
    if (clr_busy_r) begin
      ev_we = 1'b1;
      od_we = 1'b1;
      waddr = clr_idx_r;
      wdata = 8'd0;
    end else begin
      ev_we = in_xfer && is_write && !in_data.vram_addr[0];
      od_we = in_xfer && is_write && in_data.vram_addr[0];
      waddr = in_data.vram_addr[VRAM_AW-1:1];
      wdata = in_data.vram_data;
    end
  end

  // tile row address from the map byte
  always_comb begin
    map_byte = s1_r.map_bank ? od_a : ev_a;
    tile_idx = {!cfg_r.tile_data_unsigned && !map_byte[7], map_byte, s1_r.fine_y};
  end

  // even and odd byte banks
  lbpr_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram_even (
    .clk     (clk),
    .we      (ev_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (ev.map_index),
    .rdata_a (ev_a),
    .raddr_b (tile_idx),
    .rdata_b (ev_b)
  );

  lbpr_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram_odd (
    .clk     (clk),
    .we      (od_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (ev.map_index),
    .rdata_a (od_a),
    .raddr_b (tile_idx),
    .rdata_b (od_b)
  );

  // pipeline stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_xfer;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= ev;
    s2_r <= s1_r;
  end

  // pixel color, palette and grey
  always_comb begin
    bit_sel = 3'd7 - s2_r.fine_x;
    ci      = {od_b[bit_sel], ev_b[bit_sel]};
    shade   = pal_lookup(cfg_r.bg_palette, ci);
    res             = '0;
    res.pixel_valid = s2_r.pixel_valid;
    res.line        = s2_r.line;
    res.mode        = s2_r.mode;
    res.vblank_irq  = s2_r.vblank_irq;
    if (s2_r.pixel_valid) begin
      res.pixel_x    = s2_r.pixel_x;
      res.shade      = shade;
      res.argb_color = shade_argb(shade);
    end
  end

  lbpr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_vld_r),
    .push_item (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // outstanding results never exceed the queue
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= OUTQ_CW'(OUTQ_DEPTH))
    else $error("outstanding result count above queue depth");

  // a shown result was counted as outstanding
  a_out_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != '0))
    else $error("result shown with nothing outstanding");

  // pixels come only from drawing dots
  a_pix_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.pixel_valid) |-> (out_data.mode == MODE_DRAW))
    else $error("pixel outside drawing mode");

  // interrupt only on a vertical blank result without a pixel
  a_irq_vblank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.vblank_irq)
      |-> (out_data.mode == MODE_VBLANK && !out_data.pixel_valid))
    else $error("vblank interrupt outside vertical blank");

  // no item transfer while the clearing pass runs
  a_no_xfer_clr: assert property (@(posedge clk) disable iff (!rst_n)
    $past(clr_busy_r) && clr_busy_r |-> !s1_vld_r)
    else $error("item in flight during clearing pass");

endmodule
